### hdl/wfb_pkg.sv
package wfb_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CHECK  = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] source_addr;
    logic        source_any;
    logic [31:0] dest_addr;
    logic        dest_any;
    logic [15:0] delay_ticks;
  } req_t;

  typedef struct packed {
    logic        drop;
    logic        found;
    logic [15:0] violation_count;
    logic        table_full;
  } rsp_t;

  // one table entry, valid flag kept apart
  typedef struct packed {
    logic [31:0] source;
    logic        source_wild;
    logic [31:0] dest;
    logic        dest_wild;
    logic [31:0] start_time;
    logic [15:0] delay;
    logic [15:0] violations;
  } slot_t;

  // item walking down the row of cells
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] source;
    logic        source_any;
    logic [31:0] dest;
    logic        dest_any;
    logic [15:0] delay;
    logic        done;   // placed, matched or removed upstream
    logic        shift;  // removal happened upstream: pull from right neighbor
    logic [15:0] violations;
  } tok_t;

endpackage

### hdl/wfb_if.sv
interface wfb_req_if import wfb_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface wfb_rsp_if import wfb_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/wfb_cell.sv
module wfb_cell import wfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] now,
  input  logic        tok_in_vld,
  input  tok_t        tok_in,
  input  logic        nb_vld_in,
  input  slot_t       nb_in,
  output logic        vld_out,
  output slot_t       slot_out,
  output logic        tok_out_vld,
  output tok_t        tok_out
);

  logic        vld;
  logic        vld_next;
  slot_t       slot;
  slot_t       slot_next;
  tok_t        tok_next;
  logic        src_hit;
  logic        dst_hit;
  logic        exact;
  logic [31:0] age;
  logic        elapsed;

  assign src_hit = slot.source_wild || (slot.source == tok_in.source);
  assign dst_hit = slot.dest_wild || (slot.dest == tok_in.dest);
  assign exact = (slot.source_wild == tok_in.source_any) &&
                 (tok_in.source_any || (slot.source == tok_in.source)) &&
                 (slot.dest_wild == tok_in.dest_any) &&
                 (tok_in.dest_any || (slot.dest == tok_in.dest));
  assign age = now - slot.start_time;
  assign elapsed = age >= {16'd0, slot.delay};

  always_comb begin
    vld_next  = vld;
    slot_next = slot;
    tok_next  = tok_in;
    if (tok_in_vld) begin
      unique case (tok_in.command)
        CMD_ADD: begin
          if (!tok_in.done && !vld) begin
            vld_next              = 1'b1;
            slot_next.source_wild = tok_in.source_any;
            slot_next.source      = tok_in.source_any ? 32'd0 : tok_in.source;
            slot_next.dest_wild   = tok_in.dest_any;
            slot_next.dest        = tok_in.dest_any ? 32'd0 : tok_in.dest;
            slot_next.start_time  = now;
            slot_next.delay       = tok_in.delay;
            slot_next.violations  = 16'd0;
            tok_next.done         = 1'b1;
          end
        end
        CMD_CHECK: begin
          if (!tok_in.done && vld && src_hit && dst_hit) begin
            tok_next.done = 1'b1;
            if (elapsed && !(&slot.violations)) begin
              slot_next.violations = slot.violations + 16'd1;
            end
          end
        end
        CMD_REMOVE: begin
          if (tok_in.shift) begin
            vld_next  = nb_vld_in;
            slot_next = nb_in;
          end else if (vld && exact) begin
            tok_next.done       = 1'b1;
            tok_next.shift      = 1'b1;
            tok_next.violations = slot.violations;
            vld_next            = nb_vld_in;
            slot_next           = nb_in;
          end
        end
        CMD_TICK: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld         <= 1'b0;
      tok_out_vld <= 1'b0;
    end else begin
      vld         <= vld_next;
      tok_out_vld <= tok_in_vld;
    end
    slot    <= slot_next;
    tok_out <= tok_next;
  end

  assign vld_out  = vld;
  assign slot_out = slot;

endmodule

### hdl/wildcard_flow_block_table.sv
// channel   | dir | payload fields
// request   | in  | command, source_addr, source_any, dest_addr, dest_any, delay_ticks
// response  | out | drop, found, violation_count, table_full
//
// Each item walks the row of cells, one cell per cycle, from the head register through
// every cell to the response register.
// One item is in flight at a time; request.ready is low from acceptance until the
// response is taken. A tick also walks the row; time advances when it is accepted.
// Reset (synchronous, rst high) empties the table and zeroes time; no clearing pass.
// A stalled response holds its value and keeps request.ready low.
module wildcard_flow_block_table import wfb_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input logic clk,
  input logic rst,
  wfb_req_if.sink request,
  wfb_rsp_if.source response
);

  logic                   busy;
  logic [31:0]            now;
  logic                   head_vld;
  tok_t                   head;
  logic [TABLE_ENTRIES:0] tok_vld;
  tok_t                   tok [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES:0] link_vld;
  slot_t                  link [TABLE_ENTRIES+1];
  logic                   rsp_valid;
  rsp_t                   rsp;
  logic                   req_fire;
  logic                   rsp_fire;
  tok_t                   tail;

  assign req_fire = request.valid && request.ready;
  assign rsp_fire = response.valid && response.ready;
  assign request.ready = !busy;
  assign response.valid = rsp_valid;
  assign response.payload = rsp;

  // right end of the row: an empty slot
  assign link_vld[TABLE_ENTRIES] = 1'b0;
  assign link[TABLE_ENTRIES] = '0;

  assign tok_vld[0] = head_vld;
  assign tok[0] = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      now      <= 32'd0;
      head_vld <= 1'b0;
    end else begin
      head_vld <= req_fire;
      if (req_fire) begin
        busy <= 1'b1;
        if (request.payload.command == CMD_TICK) begin
          now <= now + 32'd1;
        end
      end else if (rsp_fire) begin
        busy <= 1'b0;
      end
    end
    head.command    <= request.payload.command;
    head.source     <= request.payload.source_addr;
    head.source_any <= request.payload.source_any;
    head.dest       <= request.payload.dest_addr;
    head.dest_any   <= request.payload.dest_any;
    head.delay      <= request.payload.delay_ticks;
    head.done       <= 1'b0;
    head.shift      <= 1'b0;
    head.violations <= 16'd0;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    wfb_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .now         (now),
      .tok_in_vld  (tok_vld[i]),
      .tok_in      (tok[i]),
      .nb_vld_in   (link_vld[i+1]),
      .nb_in       (link[i+1]),
      .vld_out     (link_vld[i]),
      .slot_out    (link[i]),
      .tok_out_vld (tok_vld[i+1]),
      .tok_out     (tok[i+1])
    );
  end

  assign tail = tok[TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (tok_vld[TABLE_ENTRIES]) begin
      rsp_valid <= 1'b1;
    end else if (rsp_fire) begin
      rsp_valid <= 1'b0;
    end
    if (tok_vld[TABLE_ENTRIES]) begin
      rsp.drop            <= (tail.command == CMD_CHECK) && tail.done;
      rsp.found           <= (tail.command == CMD_REMOVE) && tail.done;
      rsp.violation_count <= (tail.command == CMD_REMOVE) ? tail.violations : 16'd0;
      rsp.table_full      <= (tail.command == CMD_ADD) && !tail.done;
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0({tok_vld, rsp_valid}))
    else $error("more than one item in flight");

  a_resp_needs_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> busy)
    else $error("response without an accepted item");

  a_enter_row: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> tok_vld[0] && busy)
    else $error("accepted item did not enter the row");

  a_tail_to_resp: assert property (@(posedge clk) disable iff (rst)
    tok_vld[TABLE_ENTRIES] |=> rsp_valid)
    else $error("item left the row without a response");

endmodule

### test/flow_table_checker.sv
module flow_table_checker import wfb_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req_item,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_item,
  output int mismatches,
  output int outstanding,
  output int compared
);
  timeunit 1ns;
  timeprecision 1ps;

  // live flows form a prefix 0..flow_count-1, oldest first
  slot_t flows [ENTRIES];
  int flow_count;
  logic [31:0] now_ticks;
  rsp_t expected_rsp [$];

  function automatic rsp_t apply_flow_op(input req_t it);
    rsp_t r;
    int hit;
    logic [31:0] age;
    r = '0;
    hit = -1;
    case (it.command)
      CMD_ADD: begin
        if (flow_count == ENTRIES) begin
          r.table_full = 1'b1;
        end else begin
          flows[flow_count].source_wild = it.source_any;
          flows[flow_count].source = it.source_any ? 32'h0 : it.source_addr;
          flows[flow_count].dest_wild = it.dest_any;
          flows[flow_count].dest = it.dest_any ? 32'h0 : it.dest_addr;
          flows[flow_count].start_time = now_ticks;
          flows[flow_count].delay = it.delay_ticks;
          flows[flow_count].violations = 16'h0;
          flow_count++;
        end
      end
      CMD_CHECK: begin
        // packet wildcard flags play no part in a lookup
        for (int i = 0; i < flow_count; i++) begin
          if (hit < 0 && (flows[i].source_wild || flows[i].source == it.source_addr) &&
              (flows[i].dest_wild || flows[i].dest == it.dest_addr))
            hit = i;
        end
        if (hit >= 0) begin
          r.drop = 1'b1;
          age = now_ticks - flows[hit].start_time;
          if (age >= {16'h0, flows[hit].delay} && flows[hit].violations != 16'hFFFF)
            flows[hit].violations = flows[hit].violations + 16'd1;
        end
      end
      CMD_REMOVE: begin
        for (int i = 0; i < flow_count; i++) begin
          if (hit < 0 && flows[i].source_wild == it.source_any &&
              (it.source_any || flows[i].source == it.source_addr) &&
              flows[i].dest_wild == it.dest_any &&
              (it.dest_any || flows[i].dest == it.dest_addr))
            hit = i;
        end
        if (hit >= 0) begin
          r.found = 1'b1;
          r.violation_count = flows[hit].violations;
          for (int j = hit; j < flow_count - 1; j++)
            flows[j] = flows[j + 1];
          flow_count--;
        end
      end
      default: begin
        now_ticks = now_ticks + 32'd1;
      end
    endcase
    return r;
  endfunction

  function automatic int field_mismatches(input rsp_t want, input rsp_t got);
    int n;
    n = 0;
    if (got.drop !== want.drop) begin
      $error("drop: expected %0d, got %0d", want.drop, got.drop);
      n++;
    end
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      n++;
    end
    if (got.violation_count !== want.violation_count) begin
      $error("violation_count: expected %0d, got %0d", want.violation_count,
             got.violation_count);
      n++;
    end
    if (got.table_full !== want.table_full) begin
      $error("table_full: expected %0d, got %0d", want.table_full, got.table_full);
      n++;
    end
    return n;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    int bad;
    bad = 0;
    if (rst) begin
      flow_count = 0;
      now_ticks = '0;
      expected_rsp.delete();
      mismatches <= 0;
      outstanding <= 0;
      compared <= 0;
    end else begin
      // only one item is in flight, so a result always belongs to an older request
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $error("response item with no request outstanding");
          bad = 1;
        end else begin
          want = expected_rsp.pop_front();
          bad = field_mismatches(want, rsp_item);
          compared <= compared + 1;
        end
      end
      if (req_valid && req_ready)
        expected_rsp.push_back(apply_flow_op(req_item));
      mismatches <= mismatches + bad;
      outstanding <= expected_rsp.size();
    end
  end

endmodule

### test/tb_wildcard_flow_block_table.sv
module tb_wildcard_flow_block_table;
  timeunit 1ns;
  timeprecision 1ps;
  import wfb_pkg::*;

  localparam int ENTRIES = 16;
  localparam int IDLE_LIMIT = 1000;
  localparam int PHASE_ITEMS = 450;
  localparam logic [31:0] ADDR_POOL [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0001,
                                            32'hC0A8_0101, 32'h7F00_0001, 32'hAC10_0002};
  localparam int REQ_IDLE_PCT [4] = '{0, 56, 0, 11};
  localparam int RSP_STALL_PCT [4] = '{0, 0, 56, 11};

  logic clk = 1'b0;
  logic rst;
  int req_idle_pct;
  int rsp_stall_pct;
  int idle_cycles;
  int mismatches;
  int outstanding;
  int compared;
  int sent_by_cmd [4];
  req_t recent_adds [$];

  always #4 clk = ~clk;

  wfb_req_if request ();
  wfb_rsp_if response ();

  wildcard_flow_block_table #(.TABLE_ENTRIES(ENTRIES)) dut (
    .clk(clk),
    .rst(rst),
    .request(request),
    .response(response)
  );

  flow_table_checker #(.ENTRIES(ENTRIES)) chk (
    .clk(clk),
    .rst(rst),
    .req_valid(request.valid),
    .req_ready(request.ready),
    .req_item(request.payload),
    .rsp_valid(response.valid),
    .rsp_ready(response.ready),
    .rsp_item(response.payload),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .compared(compared)
  );

  always @(posedge clk) begin
    response.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (request.valid && request.ready) || (response.valid && response.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic req_t make_req(input logic [1:0] cmd, input logic [31:0] src,
                                    input logic src_any, input logic [31:0] dst,
                                    input logic dst_any, input logic [15:0] dly);
    req_t it;
    it.command = cmd;
    it.source_addr = src;
    it.source_any = src_any;
    it.dest_addr = dst;
    it.dest_any = dst_any;
    it.delay_ticks = dly;
    return it;
  endfunction

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(0, 9) < 7)
      return ADDR_POOL[$urandom_range(0, 5)];
    return $urandom();
  endfunction

  // fill_heavy shifts the mix toward adds so the table reaches full; otherwise it drains
  function automatic req_t rand_item(input bit fill_heavy);
    req_t it;
    req_t old;
    int pick;
    int add_w;
    int rem_w;
    it = make_req(CMD_TICK, $urandom(), 1'($urandom_range(0, 1)), $urandom(),
                  1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
    add_w = fill_heavy ? 40 : 15;
    rem_w = fill_heavy ? 10 : 35;
    pick = $urandom_range(0, 99);
    if (pick < add_w) begin
      it.command = CMD_ADD;
      it.source_any = ($urandom_range(0, 3) == 0);
      it.dest_any = ($urandom_range(0, 3) == 0);
      it.source_addr = pick_addr();
      it.dest_addr = pick_addr();
      pick = $urandom_range(0, 19);
      if (pick < 12)
        it.delay_ticks = 16'($urandom_range(0, 6));
      else if (pick < 15)
        it.delay_ticks = 16'h0;
      recent_adds.push_back(it);
      if (recent_adds.size() > 32)
        void'(recent_adds.pop_front());
    end else if (pick < add_w + 30) begin
      it.command = CMD_CHECK;
      it.source_addr = pick_addr();
      it.dest_addr = pick_addr();
      if (recent_adds.size() != 0 && $urandom_range(0, 1) == 1) begin
        old = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
        if (!old.source_any) it.source_addr = old.source_addr;
        if (!old.dest_any) it.dest_addr = old.dest_addr;
      end
    end else if (pick < add_w + 30 + rem_w) begin
      it.command = CMD_REMOVE;
      if (recent_adds.size() != 0 && $urandom_range(0, 3) != 0) begin
        old = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
        it.source_any = old.source_any;
        it.dest_any = old.dest_any;
        // the stored address of a wildcard field must not matter
        if (!old.source_any) it.source_addr = old.source_addr;
        if (!old.dest_any) it.dest_addr = old.dest_addr;
      end else begin
        it.source_any = ($urandom_range(0, 3) == 0);
        it.dest_any = ($urandom_range(0, 3) == 0);
        it.source_addr = pick_addr();
        it.dest_addr = pick_addr();
      end
    end
    return it;
  endfunction

  task automatic send_req(input req_t it);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      request.valid <= 1'b0;
      @(posedge clk);
    end
    request.valid <= 1'b1;
    request.payload <= it;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
    sent_by_cmd[it.command]++;
  endtask

  initial begin
    rst = 1'b1;
    request.valid = 1'b0;
    request.payload = '0;
    response.ready = 1'b0;
    req_idle_pct = 0;
    rsp_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty table, then exact, wildcard-source and wildcard-dest entries
    send_req(make_req(CMD_CHECK, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 16'h0));
    send_req(make_req(CMD_REMOVE, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 16'h0));
    send_req(make_req(CMD_ADD, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 16'h0));
    send_req(make_req(CMD_ADD, 32'h1234_5678, 1'b1, 32'hC0A8_0001, 1'b0, 16'd2));
    send_req(make_req(CMD_ADD, 32'h0A00_0002, 1'b0, 32'hDEAD_BEEF, 1'b1, 16'hFFFF));
    send_req(make_req(CMD_CHECK, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1, 16'hFFFF));
    send_req(make_req(CMD_CHECK, 32'h5555_5555, 1'b0, 32'hC0A8_0001, 1'b0, 16'h0));
    send_req(make_req(CMD_TICK, 32'h0, 1'b0, 32'h0, 1'b0, 16'h0));
    send_req(make_req(CMD_TICK, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
    send_req(make_req(CMD_CHECK, 32'hAAAA_AAAA, 1'b0, 32'hC0A8_0001, 1'b0, 16'h0));
    send_req(make_req(CMD_CHECK, 32'h0A00_0002, 1'b0, 32'h0000_0001, 1'b0, 16'h0));
    send_req(make_req(CMD_REMOVE, 32'h9999_0000, 1'b1, 32'hC0A8_0001, 1'b0, 16'h0));
    send_req(make_req(CMD_REMOVE, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 16'h0));
    send_req(make_req(CMD_REMOVE, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 16'h0));

    // count violations on one entry and read them back
    send_req(make_req(CMD_ADD, 32'h7F00_0001, 1'b0, 32'h7F00_0002, 1'b0, 16'h0));
    repeat (24)
      send_req(make_req(CMD_CHECK, 32'h7F00_0001, 1'b0, 32'h7F00_0002, 1'b0, 16'h0));
    send_req(make_req(CMD_REMOVE, 32'h7F00_0001, 1'b0, 32'h7F00_0002, 1'b0, 16'h0));

    // fill to capacity, one add past it, then first-match ordering
    for (int i = 0; i < ENTRIES - 1; i++)
      send_req(make_req(CMD_ADD, 32'hC633_6400 + i, i == 12, ~(32'hC633_6400 + i), i == 12,
                        16'(i)));
    send_req(make_req(CMD_ADD, 32'h0101_0101, 1'b0, 32'h0202_0202, 1'b0, 16'h0));
    send_req(make_req(CMD_CHECK, 32'hC633_6403, 1'b0, ~32'hC633_6403, 1'b0, 16'h0));
    send_req(make_req(CMD_CHECK, 32'h3C3C_3C3C, 1'b0, 32'hC3C3_C3C3, 1'b0, 16'h0));

    for (int p = 0; p < 4; p++) begin
      req_idle_pct = REQ_IDLE_PCT[p];
      rsp_stall_pct <= RSP_STALL_PCT[p];
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_req(rand_item(((p * PHASE_ITEMS + n) / 150) % 2 == 0));
    end
    request.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);

    $display("summary: %0d add, %0d check, %0d remove, %0d tick items sent",
             sent_by_cmd[CMD_ADD], sent_by_cmd[CMD_CHECK], sent_by_cmd[CMD_REMOVE],
             sent_by_cmd[CMD_TICK]);
    $display("summary: %0d responses compared over four idle/stall phases, %0d mismatches",
             compared, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### wildcard_flow_block_table.f
hdl/wfb_pkg.sv
hdl/wfb_if.sv
hdl/wfb_cell.sv
hdl/wildcard_flow_block_table.sv
test/flow_table_checker.sv
test/tb_wildcard_flow_block_table.sv
